/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/cmdtok_pkg.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared types, codes, byte constants and limits of the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmdtok_pkg;

	localparam int COMMAND_LIMIT = 32;
	localparam int TOKEN_LIMIT   = 32;
	localparam int LENGTH_LIMIT  = 128;

	localparam int CMD_CAP = (COMMAND_LIMIT < 32) ? COMMAND_LIMIT : 32;
	localparam int TOK_CAP = (TOKEN_LIMIT < 32) ? TOKEN_LIMIT : 32;
	localparam int LEN_CAP = (LENGTH_LIMIT < 255) ? LENGTH_LIMIT : 255;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMANDS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN_LENGTH = 2'd2;

	localparam logic [5:0] RST_MAX_COMMANDS     = 6'd20;
	localparam logic [5:0] RST_MAX_TOKENS       = 6'd20;
	localparam logic [7:0] RST_MAX_TOKEN_LENGTH = 8'd80;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;

	typedef enum logic [2:0] {
		KIND_CHAR        = 3'd0,
		KIND_TOKEN_END   = 3'd1,
		KIND_COMMAND_END = 3'd2,
		KIND_LINE_END    = 3'd3,
		KIND_ERROR       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_COMMANDS = 2'd1,
		ERR_TOKENS   = 2'd2,
		ERR_LENGTH   = 2'd3
	} err_t;

	typedef struct packed {
		logic [4:0] cmd;
		logic [4:0] tok;
		logic [7:0] pos;
		logic       hold;
	} state_t;

	typedef struct packed {
		logic [5:0] cmd_lim;
		logic [5:0] tok_lim;
		logic [7:0] len_lim;
	} limits_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [4:0] cmd;
		logic [4:0] tok;
		logic [7:0] pos;
		logic       pipe;
		err_t       err;
	} result_t;

endpackage

/* rtl/cmdtok_step.sv */
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Classifies one byte against the line state and forms the next state and
// the result transaction, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmdtok_step
	import cmdtok_pkg::*;
(
	input  logic [7:0] ch,
	input  state_t     st,
	input  limits_t    lim,
	output state_t     nxt,
	output logic       emit,
	output result_t    res
);

	logic is_blank;
	logic is_cmd_sep;
	logic is_tok_sep;
	logic cmd_over;
	logic tok_over;
	logic len_over;

	assign is_blank   = ch inside {CH_SPACE, CH_TAB};
	assign is_cmd_sep = ch inside {CH_PIPE, CH_SEMI};
	assign is_tok_sep = ch inside {CH_SPACE, CH_TAB, CH_LT, CH_GT, CH_AMP, CH_QUOTE};
	assign cmd_over   = ({1'b0, st.cmd} + 6'd1) >= lim.cmd_lim;
	assign tok_over   = ({1'b0, st.tok} + 6'd1) >= lim.tok_lim;
	assign len_over   = st.pos >= lim.len_lim;

	always_comb begin
		nxt      = st;
		emit     = 1'b0;
		res.kind = KIND_CHAR;
		res.ch   = 8'd0;
		res.cmd  = st.cmd;
		res.tok  = st.tok;
		res.pos  = st.pos;
		res.pipe = 1'b0;
		res.err  = ERR_NONE;
		if (ch == CH_NL) begin
			emit     = !st.hold;
			res.kind = KIND_LINE_END;
			nxt      = '0;
		end else if (ch == CH_NUL || st.hold) begin
			emit = 1'b0;
		end else if (is_blank && st.pos == 8'd0) begin
			emit = 1'b0;
		end else if (is_cmd_sep) begin
			emit = 1'b1;
			if (cmd_over) begin
				nxt.hold = 1'b1;
				res.kind = KIND_ERROR;
				res.err  = ERR_COMMANDS;
			end else begin
				res.kind = KIND_COMMAND_END;
				res.pipe = (ch == CH_PIPE);
				nxt.cmd  = st.cmd + 5'd1;
				nxt.tok  = 5'd0;
				nxt.pos  = 8'd0;
			end
		end else if (is_tok_sep) begin
			emit = 1'b1;
			if (tok_over) begin
				nxt.hold = 1'b1;
				res.kind = KIND_ERROR;
				res.err  = ERR_TOKENS;
			end else begin
				res.kind = KIND_TOKEN_END;
				nxt.tok  = st.tok + 5'd1;
				nxt.pos  = 8'd0;
			end
		end else begin
			emit = 1'b1;
			if (len_over) begin
				nxt.hold = 1'b1;
				res.kind = KIND_ERROR;
				res.err  = ERR_LENGTH;
			end else begin
				res.kind = KIND_CHAR;
				res.ch   = ch;
				nxt.pos  = st.pos + 8'd1;
			end
		end
	end

endmodule

/* rtl/command_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a command line, one byte per transaction, into token characters,
// token ends, command ends, line ends and errors.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   char_in
//   result    out        out_valid/out_stall event_kind .. error_code
//   config    in         cfg_we              cfg_index, cfg_data
//
// A byte is captured in the input register and then resolved into the result
// register, so one byte is taken every cycle while in_stall stays low. The
// line state updates in that same step.
// Reset clears the line state and loads the register defaults.
// in_stall rises only while a held result is stalled and a byte waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module command_line_tokenizer
	import cmdtok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            char_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            event_kind,
	output logic [7:0]            char_out,
	output logic [4:0]            command_index,
	output logic [4:0]            token_index,
	output logic [7:0]            char_position,
	output logic                  pipes_to_next,
	output logic [1:0]            error_code,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [5:0] max_commands_q;
	logic [5:0] max_tokens_q;
	logic [7:0] max_len_q;

	logic       valid_s1;
	logic [7:0] char_s1;

	state_t     state_q;
	state_t     state_nxt;
	limits_t    lim;
	logic       emit;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_commands_q <= RST_MAX_COMMANDS;
			max_tokens_q   <= RST_MAX_TOKENS;
			max_len_q      <= RST_MAX_TOKEN_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_COMMANDS:     max_commands_q <= cfg_data[5:0];
				CFG_MAX_TOKENS:       max_tokens_q   <= cfg_data[5:0];
				CFG_MAX_TOKEN_LENGTH: max_len_q      <= cfg_data;
				default:              max_len_q      <= max_len_q;
			endcase
		end
	end

	assign lim.cmd_lim = (max_commands_q > 6'(CMD_CAP)) ? 6'(CMD_CAP) : max_commands_q;
	assign lim.tok_lim = (max_tokens_q > 6'(TOK_CAP)) ? 6'(TOK_CAP) : max_tokens_q;
	assign lim.len_lim = (max_len_q > 8'(LEN_CAP)) ? 8'(LEN_CAP) : max_len_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
		end
	end

	cmdtok_step u_step (
		.ch   (char_s1),
		.st   (state_q),
		.lim  (lim),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = res_q.kind;
	assign char_out      = res_q.ch;
	assign command_index = res_q.cmd;
	assign token_index   = res_q.tok;
	assign char_position = res_q.pos;
	assign pipes_to_next = res_q.pipe;
	assign error_code    = res_q.err;

	`ASSERT_IMPL(a_err_holds, clk, arst_n, out_valid_q && res_q.kind == KIND_ERROR, state_q.hold, "error result without hold")
	`ASSERT_IMPL(a_stall_src, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled without cause")
	`ASSERT_IMPL(a_err_code, clk, arst_n, out_valid_q && res_q.kind != KIND_ERROR, res_q.err == ERR_NONE, "error code on non-error result")
	`ASSERT_NEXT(a_hold_quiet, clk, arst_n, state_q.hold && !(advance && char_s1 == CH_NL), state_q.hold, "hold dropped without newline")

endmodule

/* verif/tokenizer_checker.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer checker
// Watches the byte, result and register write ports of the tokenizer. It keeps
// its own copy of the line state and the limit registers, predicts the event
// that each accepted byte causes, and compares every accepted result with the
// oldest predicted event, field by field. It hands its mismatch count and the
// number of events still awaited to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tokenizer_checker
	import cmdtok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            char_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [2:0]            event_kind,
	input  logic [7:0]            char_out,
	input  logic [4:0]            command_index,
	input  logic [4:0]            token_index,
	input  logic [7:0]            char_position,
	input  logic                  pipes_to_next,
	input  logic [1:0]            error_code,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	logic [5:0] max_commands;
	logic [5:0] max_tokens;
	logic [7:0] max_token_length;

	logic [4:0] cmd_cnt;
	logic [4:0] tok_cnt;
	logic [7:0] pos;
	logic       hold;

	result_t expected_events[$];
	result_t want;

	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	task automatic push_event(input kind_t k, input logic [7:0] ch, input logic [7:0] p,
		input logic pipe, input err_t e);
		result_t r;
		r.kind = k;
		r.ch   = ch;
		r.cmd  = cmd_cnt;
		r.tok  = tok_cnt;
		r.pos  = p;
		r.pipe = pipe;
		r.err  = e;
		expected_events.push_back(r);
	endtask

	task automatic tokenize_byte(input logic [7:0] c);
		int cmd_lim;
		int tok_lim;
		int len_lim;
		cmd_lim = (int'(max_commands) > CMD_CAP) ? CMD_CAP : int'(max_commands);
		tok_lim = (int'(max_tokens) > TOK_CAP) ? TOK_CAP : int'(max_tokens);
		len_lim = (int'(max_token_length) > LEN_CAP) ? LEN_CAP : int'(max_token_length);
		if (c == CH_NL) begin
			if (!hold)
				push_event(KIND_LINE_END, 8'd0, pos, 1'b0, ERR_NONE);
			cmd_cnt = '0;
			tok_cnt = '0;
			pos     = '0;
			hold    = 1'b0;
		end else if (c == CH_NUL || hold) begin
		end else if ((c == CH_SPACE || c == CH_TAB) && pos == 8'd0) begin
		end else if (c == CH_PIPE || c == CH_SEMI) begin
			if (int'(cmd_cnt) + 1 >= cmd_lim) begin
				hold = 1'b1;
				push_event(KIND_ERROR, 8'd0, pos, 1'b0, ERR_COMMANDS);
			end else begin
				push_event(KIND_COMMAND_END, 8'd0, pos, c == CH_PIPE, ERR_NONE);
				cmd_cnt = cmd_cnt + 5'd1;
				tok_cnt = '0;
				pos     = '0;
			end
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LT || c == CH_GT ||
			c == CH_AMP || c == CH_QUOTE) begin
			if (int'(tok_cnt) + 1 >= tok_lim) begin
				hold = 1'b1;
				push_event(KIND_ERROR, 8'd0, pos, 1'b0, ERR_TOKENS);
			end else begin
				push_event(KIND_TOKEN_END, 8'd0, pos, 1'b0, ERR_NONE);
				tok_cnt = tok_cnt + 5'd1;
				pos     = '0;
			end
		end else if (int'(pos) >= len_lim) begin
			hold = 1'b1;
			push_event(KIND_ERROR, 8'd0, pos, 1'b0, ERR_LENGTH);
		end else begin
			push_event(KIND_CHAR, c, pos, 1'b0, ERR_NONE);
			pos = pos + 8'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_commands     = RST_MAX_COMMANDS;
			max_tokens       = RST_MAX_TOKENS;
			max_token_length = RST_MAX_TOKEN_LENGTH;
			cmd_cnt          = '0;
			tok_cnt          = '0;
			pos              = '0;
			hold             = 1'b0;
			expected_events.delete();
			fail_count       = 0;
			pending          = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					flag_mismatch("result with no event awaited, kind", event_kind, 0);
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind)
						flag_mismatch("event_kind", event_kind, want.kind);
					if (char_out !== want.ch)
						flag_mismatch("char_out", char_out, want.ch);
					if (command_index !== want.cmd)
						flag_mismatch("command_index", command_index, want.cmd);
					if (token_index !== want.tok)
						flag_mismatch("token_index", token_index, want.tok);
					if (char_position !== want.pos)
						flag_mismatch("char_position", char_position, want.pos);
					if (pipes_to_next !== want.pipe)
						flag_mismatch("pipes_to_next", pipes_to_next, want.pipe);
					if (error_code !== want.err)
						flag_mismatch("error_code", error_code, want.err);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_COMMANDS:     max_commands     = cfg_data[5:0];
					CFG_MAX_TOKENS:       max_tokens       = cfg_data[5:0];
					CFG_MAX_TOKEN_LENGTH: max_token_length = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tokenize_byte(char_in);
			pending = expected_events.size();
		end
	end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Feeds the tokenizer a directed set of bytes at the reset limits, then runs
// phases of random command lines under several limit settings, the extremes
// among them. Lines are mostly well formed, with some driven up to and past
// the command, token and length limits, mixed with noise. Both sides idle at
// random; the receiver also holds off once for a long stretch. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cmdtok_pkg::*;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam int SETTLE_CYCLES  = 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            char_in = 8'd0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            event_kind;
	logic [7:0]            char_out;
	logic [4:0]            command_index;
	logic [4:0]            token_index;
	logic [7:0]            char_position;
	logic                  pipes_to_next;
	logic [1:0]            error_code;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;

	int  items_sent = 0;
	int  idle_cycles = 0;
	int  hold_requests = 0;
	int  holds_served = 0;
	bit  sender_no_idle = 1'b0;
	bit  receiver_no_idle = 1'b0;
	int  cur_cmd = RST_MAX_COMMANDS;
	int  cur_tok = RST_MAX_TOKENS;
	int  cur_len = RST_MAX_TOKEN_LENGTH;

	command_line_tokenizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.char_out      (char_out),
		.command_index (command_index),
		.token_index   (token_index),
		.char_position (char_position),
		.pipes_to_next (pipes_to_next),
		.error_code    (error_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tokenizer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.char_out      (char_out),
		.command_index (command_index),
		.token_index   (token_index),
		.char_position (char_position),
		.pipes_to_next (pipes_to_next),
		.error_code    (error_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int draw_idle();
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
	endfunction

	function automatic int capped(input int v, input int c);
		return (v > c) ? c : v;
	endfunction

	function automatic bit is_special(input logic [7:0] b);
		return b inside {CH_NUL, CH_TAB, CH_NL, CH_SPACE, CH_QUOTE, CH_AMP, CH_SEMI,
			CH_LT, CH_GT, CH_PIPE};
	endfunction

	function automatic logic [7:0] pick_delimiter();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LT;
			3: return CH_GT;
			4: return CH_AMP;
			default: return CH_QUOTE;
		endcase
	endfunction

	function automatic logic [7:0] pick_token_char();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (is_special(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_noise();
		if ($urandom_range(0, 2) != 0)
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return pick_delimiter();
			1: return ($urandom_range(0, 1) != 0) ? CH_PIPE : CH_SEMI;
			2: return CH_NL;
			default: return CH_NUL;
		endcase
	endfunction

	task automatic offer_byte(input logic [7:0] b);
		int gap;
		gap = sender_no_idle ? 0 : draw_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [7:0] c, input logic [7:0] t, input logic [7:0] l);
		write_cfg(CFG_MAX_COMMANDS, c);
		write_cfg(CFG_MAX_TOKENS, t);
		write_cfg(CFG_MAX_TOKEN_LENGTH, l);
		cur_cmd = c[5:0];
		cur_tok = t[5:0];
		cur_len = l;
	endtask

	task automatic send_token(input int len);
		int i;
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 2))
				offer_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				offer_byte(CH_NUL);
			offer_byte(pick_token_char());
		end
	endtask

	task automatic send_line();
		int mode;
		int ncmd;
		int ntok;
		int c;
		int t;
		int len;
		mode = $urandom_range(0, 15);
		if (mode >= 14) begin
			repeat ($urandom_range(1, 24)) offer_byte(pick_noise());
		end else begin
			ncmd = 1;
			if (mode == 9 || mode == 10)
				ncmd = capped(cur_cmd, CMD_CAP) + $urandom_range(0, 1);
			else if (mode <= 8)
				ncmd = $urandom_range(1, 3);
			if (ncmd < 1)
				ncmd = 1;
			for (c = 0; c < ncmd; c++) begin
				ntok = $urandom_range(1, 3);
				if (mode == 11 || mode == 12)
					ntok = capped(cur_tok, TOK_CAP) + $urandom_range(0, 1);
				else if (mode != 13 && mode > 8)
					ntok = 1;
				if (ntok < 1)
					ntok = 1;
				for (t = 0; t < ntok; t++) begin
					if (mode == 13)
						len = capped(cur_len, LEN_CAP) + $urandom_range(0, 1);
					else if (mode > 8)
						len = $urandom_range(0, 1);
					else
						len = $urandom_range(0, 5);
					send_token(len);
					if (t < ntok - 1)
						offer_byte(pick_delimiter());
				end
				if (c < ncmd - 1)
					offer_byte(($urandom_range(0, 1) != 0) ? CH_PIPE : CH_SEMI);
			end
		end
		if ($urandom_range(0, 9) != 0)
			offer_byte(CH_NL);
	endtask

	initial begin
		int n;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			n = receiver_no_idle ? 0 : draw_idle();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int target;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed bytes at the reset limits.
		offer_byte(CH_NUL);   offer_byte(CH_SPACE); offer_byte(CH_TAB);
		offer_byte("a");      offer_byte(8'hFF);    offer_byte(8'h01);
		offer_byte(CH_SPACE); offer_byte("b");      offer_byte(CH_TAB);
		offer_byte(CH_LT);    offer_byte(CH_GT);    offer_byte(CH_AMP);
		offer_byte(CH_QUOTE); offer_byte("c");      offer_byte(CH_NUL);
		offer_byte(CH_PIPE);  offer_byte("d");      offer_byte(CH_SEMI);
		offer_byte(8'h7F);    offer_byte(8'h80);    offer_byte(CH_NL);
		offer_byte(CH_NL);

		for (p = 0; p < PHASES; p++) begin
			drain_block();
			case (p)
				0: set_limits(8'd2, 8'd2, 8'd1);
				1: set_limits(8'd32, 8'd32, 8'd128);
				2: set_limits(8'd0, 8'd1, 8'd0);
				3: set_limits(8'd63, 8'd63, 8'd255);
				4: set_limits(8'hC3, 8'h45, 8'd5);
				5: set_limits(8'd1, 8'd0, 8'd129);
				6: set_limits(8'($urandom_range(2, 32)), 8'($urandom_range(2, 32)),
					8'($urandom_range(1, 128)));
				default: set_limits(8'(RST_MAX_COMMANDS), 8'(RST_MAX_TOKENS),
					RST_MAX_TOKEN_LENGTH);
			endcase
			if (p == 4)
				write_cfg(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
			sender_no_idle   = (p % 4 == 1);
			receiver_no_idle = (p % 4 == 2);
			target = items_sent + PHASE_ITEMS;
			if (p == 1) begin
				sender_no_idle = 1'b1;
				hold_requests++;
				repeat (6) send_line();
				sender_no_idle = 1'b0;
			end
			while (items_sent < target) begin
				send_line();
				if (p == 3 && $urandom_range(0, 15) == 0)
					drain_block();
			end
		end

		drain_block();
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
